@@ hdl/bemll_pkg.sv @@
// Shared types, sizes and helpers for the big-endian memory with reservation.
// Used by the top level and bemll_resv; no dependencies.
package bemll_pkg;

	localparam int MEMORY_BYTES = 4194304;
	localparam int ROWS         = (MEMORY_BYTES + 7) / 8;
	localparam int BANK_ROWS    = (ROWS + 1) / 2;
	localparam int BANK_IDX_W   = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;

	typedef enum logic [1:0] {
		FUNC_READ   = 2'd0,
		FUNC_WRITE  = 2'd1,
		FUNC_SET    = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [31:0] address;
		logic [1:0]  width_code;
		logic [63:0] write_data;
	} cmd_word_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        fault;
		logic        reservation_match;
	} rsp_word_t;

	// One accepted operation as seen by the reservation monitor.
	typedef struct packed {
		logic        go;
		func_t       func;
		logic [31:0] address;
		logic [3:0]  nbytes;
		logic [32:0] end_addr;
		logic        fault;
	} resv_op_t;

	function automatic logic [3:0] width_bytes(input logic [1:0] wc);
		logic [3:0] n;
		case (wc)
			2'd0:    n = 4'd1;
			2'd1:    n = 4'd2;
			2'd2:    n = 4'd4;
			default: n = 4'd8;
		endcase
		return n;
	endfunction

	// Unused leading bytes of an 8-byte lane for a given width.
	function automatic logic [2:0] lead_pad(input logic [1:0] wc);
		logic [2:0] p;
		case (wc)
			2'd0:    p = 3'd7;
			2'd1:    p = 3'd6;
			2'd2:    p = 3'd4;
			default: p = 3'd0;
		endcase
		return p;
	endfunction

endpackage

@@ hdl/big_endian_memory_with_ll_reservation.sv @@
// Top level of the big-endian byte memory with load-linked reservation.
// Depends on bemll_pkg, bemll_ram and bemll_resv.
//
// The block takes one command word per cycle while cmd_stall is low and returns
// one response word for each, in order. Memory rows of 8 bytes are split into an
// even and an odd bank, so any access of 1, 2, 4 or 8 bytes at any alignment
// touches at most one row in each bank and finishes in a single bank access:
// sustained rate is one word per clock while neither side stalls. A response
// moves from the bank read registers through the read stage into the response
// register. Writes land in the banks at the accept edge through
// byte enables, so a following read always sees them without forwarding. The
// response register and the read stage form a two-word skid, so a command is
// still taken while a finished response waits on rsp_stall. After reset the
// block sweeps all BANK_ROWS rows of both banks to zero (262144 per bank at the
// default size of 4 MiB), one row per bank per clock, holding cmd_stall high
// meanwhile. A read or write past the end of memory faults and changes nothing.
module big_endian_memory_with_ll_reservation (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  bemll_pkg::cmd_word_t  cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output bemll_pkg::rsp_word_t  rsp
);
	import bemll_pkg::*;

	// clear sweep
	logic                  clr_busy_q;
	logic [BANK_IDX_W-1:0] clr_q;

	// accept stage
	logic                  accept;
	logic                  is_rw;
	logic [3:0]            nbytes;
	logic [2:0]            pad;
	logic [2:0]            off;
	logic [BANK_IDX_W:0]   row;
	logic [BANK_IDX_W-1:0] half;
	logic                  row_odd;
	logic [32:0]           end_addr;
	logic                  fault;
	logic                  match;
	resv_op_t              op;

	// write steering
	logic [63:0]           wr_left;
	logic [127:0]          wr_win;
	logic [7:0]            mask_left;
	logic [15:0]           mask_win;
	logic                  do_write;
	logic [7:0]            be_first;
	logic [7:0]            be_second;

	// bank ports
	logic [7:0]            ev_be, od_be;
	logic [BANK_IDX_W-1:0] ev_waddr, od_waddr;
	logic [63:0]           ev_wdata, od_wdata;
	logic [BANK_IDX_W-1:0] ev_raddr;
	logic [63:0]           ev_rdata, od_rdata;

	// read stage
	logic                  valid_s1;
	logic                  read_s1;
	logic                  fault_s1;
	logic                  match_s1;
	logic                  odd_s1;
	logic [2:0]            off_s1;
	logic [2:0]            pad_s1;
	logic                  s1_adv;
	logic [127:0]          rd_win;
	logic [63:0]           rd_left;
	rsp_word_t             rsp_next;

	// response register
	logic                  out_valid_q;
	rsp_word_t             out_q;

	// Reset sweep: clear one row of each bank per cycle, then open the port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			if (clr_q == BANK_IDX_W'(BANK_ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	// The read stage may move on whenever the response register is free or drains.
	assign s1_adv    = !out_valid_q || !rsp_stall;
	assign cmd_stall = clr_busy_q || (valid_s1 && !s1_adv);
	assign accept    = cmd_valid && !cmd_stall;

	// Decode the span of the access.
	assign is_rw    = (cmd.func == FUNC_READ) || (cmd.func == FUNC_WRITE);
	assign nbytes   = width_bytes(cmd.width_code);
	assign pad      = lead_pad(cmd.width_code);
	assign off      = cmd.address[2:0];
	assign row      = cmd.address[BANK_IDX_W+3:3];
	assign half     = row[BANK_IDX_W:1];
	assign row_odd  = row[0];
	assign end_addr = {1'b0, cmd.address} + 33'(nbytes);
	assign fault    = is_rw && (end_addr > 33'(MEMORY_BYTES));

	assign op.go       = accept;
	assign op.func     = cmd.func;
	assign op.address  = cmd.address;
	assign op.nbytes   = nbytes;
	assign op.end_addr = end_addr;
	assign op.fault    = fault;

	bemll_resv u_resv (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.match  (match)
	);

	// Left-align the write value, then slide it across a two-row window.
	assign wr_left   = cmd.write_data << {pad, 3'b000};
	assign wr_win    = {wr_left, 64'd0} >> {off, 3'b000};
	assign mask_left = 8'hff << pad;
	assign mask_win  = {mask_left, 8'h00} >> off;
	assign do_write  = accept && (cmd.func == FUNC_WRITE) && !fault;
	assign be_first  = do_write ? mask_win[15:8] : 8'h00;
	assign be_second = do_write ? mask_win[7:0]  : 8'h00;

	// First row of the window sits in the even bank unless the row is odd.
	always_comb begin
		if (clr_busy_q) begin
			ev_be    = 8'hff;
			od_be    = 8'hff;
			ev_waddr = clr_q;
			od_waddr = clr_q;
			ev_wdata = '0;
			od_wdata = '0;
		end else if (row_odd) begin
			ev_be    = be_second;
			od_be    = be_first;
			ev_waddr = half + 1'b1;
			od_waddr = half;
			ev_wdata = wr_win[63:0];
			od_wdata = wr_win[127:64];
		end else begin
			ev_be    = be_first;
			od_be    = be_second;
			ev_waddr = half;
			od_waddr = half;
			ev_wdata = wr_win[127:64];
			od_wdata = wr_win[63:0];
		end
	end

	assign ev_raddr = row_odd ? half + 1'b1 : half;

	bemll_ram #(
		.DEPTH (BANK_ROWS),
		.AW    (BANK_IDX_W)
	) u_even (
		.clk     (clk),
		.wr_be   (ev_be),
		.wr_addr (ev_waddr),
		.wr_data (ev_wdata),
		.rd_en   (accept),
		.rd_addr (ev_raddr),
		.rd_data (ev_rdata)
	);

	bemll_ram #(
		.DEPTH (BANK_ROWS),
		.AW    (BANK_IDX_W)
	) u_odd (
		.clk     (clk),
		.wr_be   (od_be),
		.wr_addr (od_waddr),
		.wr_data (od_wdata),
		.rd_en   (accept),
		.rd_addr (half),
		.rd_data (od_rdata)
	);

	// Read stage control; bank read data holds until the next accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1  <= (cmd.func == FUNC_READ);
			fault_s1 <= fault;
			match_s1 <= match;
			odd_s1   <= row_odd;
			off_s1   <= off;
			pad_s1   <= pad;
		end
	end

	// Pull the accessed bytes to the top of the window, then right-align.
	assign rd_win  = odd_s1 ? ({od_rdata, ev_rdata} << {off_s1, 3'b000})
	                        : ({ev_rdata, od_rdata} << {off_s1, 3'b000});
	assign rd_left = rd_win[127:64];

	assign rsp_next.read_data         = (read_s1 && !fault_s1) ?
	                                    (rd_left >> {pad_s1, 3'b000}) : 64'd0;
	assign rsp_next.fault             = fault_s1;
	assign rsp_next.reservation_match = match_s1;

	// Response register: load when the read stage advances, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			out_q <= rsp_next;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

@@ hdl/bemll_ram.sv @@
// Generic 64-bit wide RAM with byte write enables and one registered read port.
// No dependencies.
module bemll_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic [7:0]    wr_be,
	input  logic [AW-1:0] wr_addr,
	input  logic [63:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [63:0]   rd_data
);

	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++) begin
			if (wr_be[i]) begin
				mem[wr_addr][i*8 +: 8] <= wr_data[i*8 +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/bemll_resv.sv @@
// Load-linked reservation monitor: holds one reserved span and reports matches.
// Depends on bemll_pkg.
module bemll_resv (
	input  logic                clk,
	input  logic                arst_n,
	input  bemll_pkg::resv_op_t op,
	output logic                match
);
	import bemll_pkg::*;

	logic        valid_q;
	logic [31:0] off_q;
	logic [3:0]  width_q;
	logic [32:0] resv_end;
	logic        overlap;
	logic        drop;

	assign match    = valid_q && (off_q == op.address) && (width_q == op.nbytes);
	assign resv_end = {1'b0, off_q} + 33'(width_q);
	assign overlap  = ({1'b0, op.address} < resv_end) && ({1'b0, off_q} < op.end_addr);
	// drop on an explicit clear, or on a good write that touches the span
	assign drop     = (op.func == FUNC_CLEAR) ||
	                  ((op.func == FUNC_WRITE) && !op.fault && valid_q && overlap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			off_q   <= '0;
			width_q <= '0;
		end else if (op.go) begin
			if (op.func == FUNC_SET) begin
				valid_q <= 1'b1;
				off_q   <= op.address;
				width_q <= op.nbytes;
			end else if (drop) begin
				valid_q <= 1'b0;
				off_q   <= '0;
				width_q <= '0;
			end
		end
	end

endmodule

@@ tb/sv/big_endian_memory_with_ll_reservation_test.sv @@
// Self-checking testbench for big_endian_memory_with_ll_reservation.
// Depends on bemll_pkg and the block's RTL: shadow memory and reservation predictor,
// a directed table of command words, then random LL/SC-style traffic under backpressure.
module big_endian_memory_with_ll_reservation_test;
	import bemll_pkg::*;

	// Access sizes as carried in width_code.
	localparam logic [1:0] SZ_BYTE  = 2'd0;
	localparam logic [1:0] SZ_HALF  = 2'd1;
	localparam logic [1:0] SZ_WORD  = 2'd2;
	localparam logic [1:0] SZ_DWORD = 2'd3;

	localparam logic [31:0] MEM_TOP     = 32'(MEMORY_BYTES);
	localparam int          RANDOM_WORDS = 525;
	localparam int          HOLD_CYCLES  = 60;
	localparam int          DRAIN_CYCLES = 20;
	// Clearing sweep after reset plus ~552 words at worst-case gaps and stalls,
	// taken several times over.
	localparam int          CYCLE_LIMIT  = 1_000_000;

	typedef struct {
		cmd_word_t word;
		bit        known;
		rsp_word_t want;
	} stim_row_t;

	typedef enum {FLOW, SPARSE, EVERY_THIRD, HEAVY} stall_mode_t;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_word_t cmd;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	big_endian_memory_with_ll_reservation DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Shadow of the block: sparse byte memory (absent key reads as zero after reset)
	// and the single reservation.
	logic [7:0]  shadow_mem [logic [31:0]];
	logic        resv_valid;
	logic [31:0] resv_offset;
	logic [3:0]  resv_nbytes;

	rsp_word_t   expected_rsp [$];
	stim_row_t   directed_rows [$];

	int          words_sent;
	int          burst_left;
	int          failures;
	int          rsp_checked;
	int          cmd_stall_cycles;
	int          cycle_count;
	int          n_read, n_write, n_set, n_clear, n_fault, n_match;
	bit          rsp_hold_req;
	logic [31:0] win_base;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop: a hung handshake must not run forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
				expected_rsp.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic cmd_word_t make_word(input func_t f, input logic [31:0] a,
			input logic [1:0] w, input logic [63:0] d);
		cmd_word_t c;
		c.func       = f;
		c.address    = a;
		c.width_code = w;
		c.write_data = d;
		return c;
	endfunction

	function automatic logic [63:0] wide_random();
		return {$urandom, $urandom};
	endfunction

	// Work out the response to one accepted command word and advance the shadow state.
	// The reservation hit is taken before the word's own effect.
	function automatic rsp_word_t predict_access(input cmd_word_t c);
		rsp_word_t   r;
		logic [3:0]  n;
		logic [32:0] span_end;
		logic [32:0] resv_end;
		logic [31:0] a;
		int          i;
		r = '0;
		n = 4'd1 << c.width_code;
		span_end = {1'b0, c.address} + 33'(n);
		resv_end = {1'b0, resv_offset} + 33'(resv_nbytes);
		r.reservation_match = resv_valid && resv_offset == c.address && resv_nbytes == n;
		n_match += r.reservation_match;
		case (c.func)
			FUNC_READ, FUNC_WRITE: begin
				if (c.func == FUNC_READ) n_read++; else n_write++;
				if (span_end > 33'(MEMORY_BYTES)) begin
					// Span runs off the end: fault, touch nothing.
					r.fault = 1'b1;
					n_fault++;
				end else if (c.func == FUNC_READ) begin
					for (i = 0; i < n; i++) begin
						a = c.address + 32'(i);
						r.read_data = {r.read_data[55:0],
							shadow_mem.exists(a) ? shadow_mem[a] : 8'h00};
					end
				end else begin
					// Drop the reservation on any overlap, then store most significant first.
					if (resv_valid && {1'b0, c.address} < resv_end
							&& {1'b0, resv_offset} < span_end) begin
						resv_valid  = 1'b0;
						resv_offset = '0;
						resv_nbytes = '0;
					end
					for (i = 0; i < n; i++) begin
						a = c.address + 32'(i);
						shadow_mem[a] = 8'((c.write_data >> ((n - 1 - i) * 8)) & 64'hff);
					end
				end
			end
			FUNC_SET: begin
				n_set++;
				resv_valid  = 1'b1;
				resv_offset = c.address;
				resv_nbytes = n;
			end
			default: begin
				n_clear++;
				resv_valid  = 1'b0;
				resv_offset = '0;
				resv_nbytes = '0;
			end
		endcase
		return r;
	endfunction

	function automatic void add_row(input func_t f, input logic [31:0] a, input logic [1:0] w,
			input logic [63:0] d, input bit known, input logic [63:0] rd, input logic flt,
			input logic mt);
		stim_row_t row;
		row.word  = make_word(f, a, w, d);
		row.known = known;
		row.want  = '{read_data: rd, fault: flt, reservation_match: mt};
		directed_rows.push_back(row);
	endfunction

	// Random read or write starting inside the current 64-byte window.
	function automatic cmd_word_t window_access();
		return make_word($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ,
			win_base + 32'($urandom_range(0, 63)), 2'($urandom_range(0, 3)), wide_random());
	endfunction

	// Offer one word from a falling edge and hold it until taken. The sender runs in
	// bursts: at the end of a burst drop valid for a random gap first. Return on the
	// falling edge after acceptance with valid still high.
	task automatic send_word(input cmd_word_t c, input bit known, input rsp_word_t want);
		rsp_word_t predicted;
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do begin
			@(posedge clk);
			if (cmd_stall) cmd_stall_cycles++;
		end while (cmd_stall);
		predicted = predict_access(c);
		expected_rsp.push_back(known ? want : predicted);
		words_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// Drop valid and hold off until every expected response has come back.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		burst_left = 0;
		while (expected_rsp.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: stall on a pattern of its own, switching modes at random, and on request
	// hold off for a long counted stretch so the skid fills up.
	initial begin : rsp_side
		stall_mode_t mode;
		int          left;
		mode = FLOW;
		left = 0;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					left = $urandom_range(8, 40);
				end
				left--;
				case (mode)
					FLOW:        rsp_stall <= 1'b0;
					SPARSE:      rsp_stall <= ($urandom_range(0, 9) < 3);
					EVERY_THIRD: rsp_stall <= (left % 3 == 0);
					default:     rsp_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	// Check every accepted response word against the oldest expectation, field by field.
	always @(posedge clk) begin : rsp_check
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected response word: read_data %h fault %b match %b",
						rsp.read_data, rsp.fault, rsp.reservation_match);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.read_data !== want.read_data || rsp.fault !== want.fault
						|| rsp.reservation_match !== want.reservation_match) begin
					failures++;
					if (failures <= 10)
						$display({"response %0d mismatch: read_data exp %h got %h, ",
							"fault exp %b got %b, match exp %b got %b"}, rsp_checked,
							want.read_data, rsp.read_data, want.fault, rsp.fault,
							want.reservation_match, rsp.reservation_match);
				end
			end
			rsp_checked++;
		end
	end

	initial begin : stimulus
		logic [31:0] a;
		logic [1:0]  w;
		int          pick;
		int          k;
		bit          hold_done;
		bit          drain_done;
		stim_row_t   row;

		arst_n       = 1'b0;
		cmd_valid    = 1'b0;
		cmd          = '0;
		rsp_hold_req = 1'b0;
		resv_valid   = 1'b0;
		resv_offset  = '0;
		resv_nbytes  = '0;
		hold_done    = 1'b0;
		drain_done   = 1'b0;
		win_base     = '0;

		// Directed table. Reads carry all-ones write data to show it is ignored.
		// Fresh memory reads zero; spans past the end fault, including 32-bit wrap.
		add_row(FUNC_READ,  32'h0,         SZ_DWORD, '1, 1, 64'h0, 1'b0, 1'b0);
		add_row(FUNC_READ,  MEM_TOP - 8,   SZ_DWORD, '1, 1, 64'h0, 1'b0, 1'b0);
		add_row(FUNC_READ,  MEM_TOP - 7,   SZ_DWORD, '1, 1, 64'h0, 1'b1, 1'b0);
		add_row(FUNC_READ,  32'hffffffff,  SZ_BYTE,  '1, 1, 64'h0, 1'b1, 1'b0);
		add_row(FUNC_WRITE, 32'hfffffff8,  SZ_DWORD, '1, 1, 64'h0, 1'b1, 1'b0);
		// Big-endian layout: first byte is the most significant.
		add_row(FUNC_WRITE, 32'h0, SZ_DWORD, 64'h0123456789abcdef, 1, 64'h0, 1'b0, 1'b0);
		add_row(FUNC_READ,  32'h0, SZ_DWORD, '1, 1, 64'h0123456789abcdef, 1'b0, 1'b0);
		add_row(FUNC_READ,  32'h3, SZ_HALF,  '1, 1, 64'h6789, 1'b0, 1'b0);
		add_row(FUNC_READ,  32'h1, SZ_WORD,  '1, 1, 64'h23456789, 1'b0, 1'b0);
		// Top of memory; only the low bytes of write data are stored.
		add_row(FUNC_WRITE, MEM_TOP - 4, SZ_WORD, 64'hffffffffdeadbeef, 1, 64'h0, 1'b0, 1'b0);
		add_row(FUNC_READ,  MEM_TOP - 1, SZ_BYTE, '1, 1, 64'hef, 1'b0, 1'b0);
		add_row(FUNC_READ,  MEM_TOP - 4, SZ_WORD, '1, 1, 64'hdeadbeef, 1'b0, 1'b0);
		// Reservation: hit needs same offset and width; adjacent write keeps it,
		// overlapping write drops it.
		add_row(FUNC_SET,   32'h10, SZ_WORD, '1, 1, 64'h0, 1'b0, 1'b0);
		add_row(FUNC_READ,  32'h10, SZ_WORD, '1, 1, 64'h0, 1'b0, 1'b1);
		add_row(FUNC_READ,  32'h10, SZ_DWORD, '1, 1, 64'h0, 1'b0, 1'b0);
		add_row(FUNC_WRITE, 32'h14, SZ_BYTE, 64'h5a, 1, 64'h0, 1'b0, 1'b0);
		add_row(FUNC_READ,  32'h10, SZ_WORD, '1, 1, 64'h0, 1'b0, 1'b1);
		add_row(FUNC_WRITE, 32'h13, SZ_BYTE, 64'ha5, 1, 64'h0, 1'b0, 1'b0);
		add_row(FUNC_READ,  32'h10, SZ_WORD, '1, 1, 64'ha5, 1'b0, 1'b0);
		// Set takes any address; a faulting write leaves the reservation alone.
		add_row(FUNC_SET,   32'hffffffff, SZ_DWORD, '1, 1, 64'h0, 1'b0, 1'b0);
		add_row(FUNC_WRITE, 32'hffffffff, SZ_DWORD, '1, 1, 64'h0, 1'b1, 1'b1);
		add_row(FUNC_READ,  32'hffffffff, SZ_DWORD, '1, 1, 64'h0, 1'b1, 1'b1);
		add_row(FUNC_CLEAR, 32'hffffffff, SZ_DWORD, '1, 1, 64'h0, 1'b0, 1'b1);
		add_row(FUNC_READ,  32'hffffffff, SZ_DWORD, '1, 1, 64'h0, 1'b1, 1'b0);
		add_row(FUNC_SET,   MEM_TOP - 2,  SZ_HALF,  '1, 1, 64'h0, 1'b0, 1'b0);
		add_row(FUNC_WRITE, MEM_TOP - 4,  SZ_DWORD, '1, 1, 64'h0, 1'b1, 1'b0);
		add_row(FUNC_READ,  MEM_TOP - 2,  SZ_HALF,  '1, 0, 64'h0, 1'b0, 1'b0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		burst_left = 0;

		// The first word waits out the clearing sweep on cmd_stall.
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_word(row.word, row.known, row.want);
		end
		wait_drained();

		// Random part: mostly load-linked / store-conditional sequences in a small window,
		// plus free window traffic, end-of-memory spans, wild addresses and stray sets and clears.
		k = 0;
		while (words_sent < directed_rows.size() + RANDOM_WORDS) begin
			if (k % 40 == 0) begin
				case ($urandom_range(0, 3))
					0:       win_base = '0;
					1:       win_base = MEM_TOP - 64;
					default: win_base = 32'($urandom_range(0, MEMORY_BYTES - 128));
				endcase
			end
			k++;
			if (!hold_done && words_sent >= 200) begin
				hold_done    = 1'b1;
				rsp_hold_req = 1'b1;
			end
			if (!drain_done && words_sent >= 380) begin
				drain_done = 1'b1;
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				a = win_base + 32'($urandom_range(0, 63));
				w = 2'($urandom_range(0, 3));
				send_word(make_word(FUNC_SET, a, w, wide_random()), 1'b0, '0);
				repeat ($urandom_range(0, 2)) send_word(window_access(), 1'b0, '0);
				send_word(make_word(FUNC_WRITE, a, w, wide_random()), 1'b0, '0);
				if ($urandom_range(0, 1))
					send_word(make_word(FUNC_READ, a, w, wide_random()), 1'b0, '0);
			end else if (pick < 75) begin
				send_word(window_access(), 1'b0, '0);
			end else if (pick < 85) begin
				send_word(make_word($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ,
					MEM_TOP - 32'($urandom_range(0, 16)), 2'($urandom_range(0, 3)),
					wide_random()), 1'b0, '0);
			end else if (pick < 95) begin
				send_word(make_word(func_t'($urandom_range(0, 3)), $urandom,
					2'($urandom_range(0, 3)), wide_random()), 1'b0, '0);
			end else begin
				send_word(make_word($urandom_range(0, 1) ? FUNC_CLEAR : FUNC_SET,
					win_base + 32'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
					wide_random()), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d words: %0d reads, %0d writes, %0d sets, %0d clears",
			words_sent, n_read, n_write, n_set, n_clear);
		$display("  %0d faulted spans, %0d reservation hits, input held off %0d cycles",
			n_fault, n_match, cmd_stall_cycles);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d failing response words", failures);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ big_endian_memory_with_ll_reservation.f @@
hdl/bemll_pkg.sv
hdl/bemll_ram.sv
hdl/bemll_resv.sv
hdl/big_endian_memory_with_ll_reservation.sv
tb/sv/big_endian_memory_with_ll_reservation_test.sv
